### rtl/dcps_pkg.sv
// shared types, widths and codes of the dual-wheel capture tachometer
package dcps_pkg;

  localparam int CounterWidthDefault = 16;
  localparam int CaptureWidth        = 16;
  localparam int ModulusWidth        = 16;
  localparam int MaxOvfWidth         = 8;
  localparam int ScaleWidth          = 31;
  localparam int SpeedWidth          = 32;
  // interval range: -65535 .. 256*65535, fits signed 25 bits
  localparam int IntervalWidth       = 25;
  localparam int DivisorWidth        = IntervalWidth - 1;
  localparam int CfgIndexWidth       = 2;
  localparam int CfgDataWidth        = ScaleWidth;

  localparam logic [MaxOvfWidth-1:0]  OvfCountMax    = '1;
  localparam logic [ModulusWidth-1:0] ModulusReset   = 16'd65535;
  localparam logic [MaxOvfWidth-1:0]  MaxOvfReset    = 8'd10;
  localparam logic [ScaleWidth-1:0]   ScaleReset     = 31'd1000000;

  localparam logic [CfgIndexWidth-1:0] CfgModulus    = 2'd0;
  localparam logic [CfgIndexWidth-1:0] CfgMaxOvf     = 2'd1;
  localparam logic [CfgIndexWidth-1:0] CfgScale      = 2'd2;

  typedef struct packed {
    logic                    overflow_event;
    logic                    left_capture_event;
    logic [CaptureWidth-1:0] left_capture_value;
    logic                    right_capture_event;
    logic [CaptureWidth-1:0] right_capture_value;
  } in_t;

  typedef struct packed {
    logic signed [SpeedWidth-1:0] left_speed;
    logic signed [SpeedWidth-1:0] right_speed;
  } out_t;

  typedef enum logic [1:0] {
    StIdle,
    StUpdate,
    StStart,
    StDivide
  } dcps_state_e;

  // control from the sequencer to one wheel
  typedef struct packed {
    logic load;   // request accepted: take event fields, apply overflow
    logic calc;   // apply a pending capture to the interval
  } wheel_ctl_t;

endpackage

### rtl/dcps_wheel.sv
// per-wheel state: overflow count, previous capture and measured interval
module dcps_wheel #(
  parameter int COUNTER_WIDTH = dcps_pkg::CounterWidthDefault
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  dcps_pkg::wheel_ctl_t                      ctl_i,
  input  logic                                      overflow_i,
  input  logic                                      capture_event_i,
  input  logic [dcps_pkg::CaptureWidth-1:0]         capture_value_i,
  input  logic [dcps_pkg::ModulusWidth-1:0]         counter_modulus_i,
  input  logic [dcps_pkg::MaxOvfWidth-1:0]          max_overflows_i,
  output logic signed [dcps_pkg::IntervalWidth-1:0] interval_o
);
  import dcps_pkg::*;

  localparam int CapWidth = (COUNTER_WIDTH < CaptureWidth) ? COUNTER_WIDTH : CaptureWidth;

  logic [CapWidth-1:0]                  cap_d, cap_q;
  logic                                 pend_d, pend_q;
  logic [CapWidth-1:0]                  prev_d, prev_q;
  logic [MaxOvfWidth-1:0]               count_d, count_q;
  logic signed [IntervalWidth-1:0]      interval_d, interval_q;
  logic [MaxOvfWidth-1:0]               count_inc;
  logic [MaxOvfWidth+ModulusWidth-1:0]  prod;

  assign count_inc = (overflow_i && (count_q != OvfCountMax)) ? count_q + 1'b1 : count_q;
  assign prod      = count_q * counter_modulus_i;

  always_comb begin
    cap_d      = cap_q;
    pend_d     = pend_q;
    prev_d     = prev_q;
    count_d    = count_q;
    interval_d = interval_q;
    if (ctl_i.load) begin
      cap_d   = capture_value_i[CapWidth-1:0];
      pend_d  = capture_event_i;
      count_d = count_inc;
      if (overflow_i && (count_inc > max_overflows_i)) begin
        interval_d = '1;
      end
    end else if (ctl_i.calc && pend_q) begin
      // wraps in the interval width; the true value always fits
      interval_d = $signed(IntervalWidth'(cap_q) - IntervalWidth'(prev_q)
                           + IntervalWidth'(prod));
      prev_d     = cap_q;
      count_d    = '0;
      pend_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q     <= 1'b0;
      prev_q     <= '0;
      count_q    <= '0;
      interval_q <= '0;
    end else begin
      pend_q     <= pend_d;
      prev_q     <= prev_d;
      count_q    <= count_d;
      interval_q <= interval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cap_q <= cap_d;
  end

  assign interval_o = interval_q;

endmodule

### rtl/dcps_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module dcps_div #(
  parameter int DIVIDEND_WIDTH = dcps_pkg::ScaleWidth,
  parameter int DIVISOR_WIDTH  = dcps_pkg::DivisorWidth
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [DIVIDEND_WIDTH-1:0] dividend_i,
  input  logic [DIVISOR_WIDTH-1:0]  divisor_i,
  output logic                      busy_o,
  output logic [DIVIDEND_WIDTH-1:0] quotient_o
);

  localparam int CntWidth = $clog2(DIVIDEND_WIDTH + 1);

  logic [CntWidth-1:0]       cnt_d, cnt_q;
  logic [DIVISOR_WIDTH-1:0]  rem_d, rem_q;
  logic [DIVIDEND_WIDTH-1:0] quo_d, quo_q;
  logic [DIVISOR_WIDTH-1:0]  dvs_d, dvs_q;
  logic [DIVISOR_WIDTH:0]    trial;
  logic                      fits;

  // quo_q shifts dividend bits out at the top and quotient bits in at the bottom
  assign trial = {rem_q, quo_q[DIVIDEND_WIDTH-1]};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_comb begin
    cnt_d = cnt_q;
    rem_d = rem_q;
    quo_d = quo_q;
    dvs_d = dvs_q;
    if (start_i) begin
      cnt_d = CntWidth'(DIVIDEND_WIDTH);
      rem_d = '0;
      quo_d = dividend_i;
      dvs_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      rem_d = fits ? DIVISOR_WIDTH'(trial - {1'b0, dvs_q}) : trial[DIVISOR_WIDTH-1:0];
      quo_d = {quo_q[DIVIDEND_WIDTH-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = (cnt_q != '0);
  assign quotient_o = quo_q;

endmodule

### rtl/dual_capture_period_speed.sv
// top level: two-wheel period tachometer built from timer capture events
//
// in channel (in_valid_i / in_ready_o / in_i) takes one timer event per
// request: an overflow flag and, per wheel, a capture flag and value.
// out channel (out_valid_o / out_ready_i / out_o) gives one request per
// event with both wheel speeds, scale / interval, or -1 when the interval
// is not positive (never measured, timed out, or negative).
// cfg channel (cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i)
// writes counter modulus (0), overflow limit (1) and speed scale (2);
// it is always ready; the user must write it only while the block is idle,
// which the block itself does not enforce. from input accept to output
// valid, the accept edge applies the overflow, then come the capture update
// (8x16 multiply-add), the divider load, the bit-serial dividers (one
// quotient bit per cycle, both wheels in parallel) and the output load.
// one event is in flight at a time: a new event is taken only after the
// previous result is loaded, while that result may still sit in the output
// register. if the receiver stalls, the next result waits in the dividers
// until the register frees. reset clears all wheel state but the held
// capture value, and loads the register defaults.
module dual_capture_period_speed #(
  parameter int COUNTER_WIDTH = dcps_pkg::CounterWidthDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  dcps_pkg::in_t                       in_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output dcps_pkg::out_t                      out_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [dcps_pkg::CfgIndexWidth-1:0]  cfg_index_i,
  input  logic [dcps_pkg::CfgDataWidth-1:0]   cfg_data_i
);
  import dcps_pkg::*;

  dcps_state_e                     state_d, state_q;
  wheel_ctl_t                      wheel_ctl;
  logic                            div_start;
  logic                            out_load;
  logic                            out_valid_d, out_valid_q;
  out_t                            out_d, out_q;
  logic [ModulusWidth-1:0]         modulus_q;
  logic [MaxOvfWidth-1:0]          max_ovf_q;
  logic [ScaleWidth-1:0]           scale_q;
  logic signed [IntervalWidth-1:0] left_interval, right_interval;
  logic                            left_busy, right_busy;
  logic [ScaleWidth-1:0]           left_quo, right_quo;
  logic                            in_accept;

  assign cfg_ready_o = 1'b1;
  assign in_accept   = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= ModulusReset;
      max_ovf_q <= MaxOvfReset;
      scale_q   <= ScaleReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgModulus: modulus_q <= cfg_data_i[ModulusWidth-1:0];
        CfgMaxOvf:  max_ovf_q <= cfg_data_i[MaxOvfWidth-1:0];
        CfgScale:   scale_q   <= cfg_data_i[ScaleWidth-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    state_d        = state_q;
    in_ready_o     = 1'b0;
    wheel_ctl.load = 1'b0;
    wheel_ctl.calc = 1'b0;
    div_start      = 1'b0;
    out_load       = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o     = 1'b1;
        wheel_ctl.load = in_valid_i;
        if (in_valid_i) begin
          state_d = StUpdate;
        end
      end
      StUpdate: begin
        wheel_ctl.calc = 1'b1;
        state_d        = StStart;
      end
      StStart: begin
        div_start = 1'b1;
        state_d   = StDivide;
      end
      StDivide: begin
        if (!left_busy && !right_busy && (!out_valid_q || out_ready_i)) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  dcps_wheel #(.COUNTER_WIDTH(COUNTER_WIDTH)) u_left (
    .clk_i,
    .rst_ni,
    .ctl_i             (wheel_ctl),
    .overflow_i        (in_i.overflow_event),
    .capture_event_i   (in_i.left_capture_event),
    .capture_value_i   (in_i.left_capture_value),
    .counter_modulus_i (modulus_q),
    .max_overflows_i   (max_ovf_q),
    .interval_o        (left_interval)
  );

  dcps_wheel #(.COUNTER_WIDTH(COUNTER_WIDTH)) u_right (
    .clk_i,
    .rst_ni,
    .ctl_i             (wheel_ctl),
    .overflow_i        (in_i.overflow_event),
    .capture_event_i   (in_i.right_capture_event),
    .capture_value_i   (in_i.right_capture_value),
    .counter_modulus_i (modulus_q),
    .max_overflows_i   (max_ovf_q),
    .interval_o        (right_interval)
  );

  // a non-positive divisor is still fed; its quotient is replaced below
  dcps_div #(.DIVIDEND_WIDTH(ScaleWidth), .DIVISOR_WIDTH(DivisorWidth)) u_left_div (
    .clk_i,
    .rst_ni,
    .start_i    (div_start),
    .dividend_i (scale_q),
    .divisor_i  (left_interval[DivisorWidth-1:0]),
    .busy_o     (left_busy),
    .quotient_o (left_quo)
  );

  dcps_div #(.DIVIDEND_WIDTH(ScaleWidth), .DIVISOR_WIDTH(DivisorWidth)) u_right_div (
    .clk_i,
    .rst_ni,
    .start_i    (div_start),
    .dividend_i (scale_q),
    .divisor_i  (right_interval[DivisorWidth-1:0]),
    .busy_o     (right_busy),
    .quotient_o (right_quo)
  );

  always_comb begin
    out_d.left_speed  = (left_interval > 0) ? $signed({1'b0, left_quo}) : '1;
    out_d.right_speed = (right_interval > 0) ? $signed({1'b0, right_quo}) : '1;
    out_valid_d       = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // an accepted request always moves on to the capture update
  a_accept_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q == StUpdate)
    else $error("accepted request did not enter update");

  // both dividers run in lockstep
  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDivide |-> left_busy == right_busy)
    else $error("dividers out of step");

  // a speed is either non-negative or the -1 marker
  a_speed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((!out_o.left_speed[SpeedWidth-1] || (out_o.left_speed == '1)) &&
                     (!out_o.right_speed[SpeedWidth-1] || (out_o.right_speed == '1))))
    else $error("speed out of range");

  // a new result only comes from a finished division
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (state_q == StDivide) && !left_busy && !right_busy)
    else $error("output loaded while dividing");

  // the output register is never overwritten while it still holds a result
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !out_load)
    else $error("pending result overwritten");

endmodule

### dv/dual_capture_period_speed_tb.sv
// testbench for the two-wheel capture tachometer: directed table, random events, checker
`timescale 1ns / 1ps

module dual_capture_period_speed_tb;
  import dcps_pkg::*;

  localparam int DrainCycles = 40;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  in_t                      in_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  out_t                     out_o;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [CfgIndexWidth-1:0] cfg_index_i;
  logic [CfgDataWidth-1:0]  cfg_data_i;

  dual_capture_period_speed dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // directed row: event fields, plus a typed result where it is obvious
  typedef struct packed {
    bit          ovf;
    bit          lc;
    logic [15:0] lv;
    bit          rc;
    logic [15:0] rv;
    bit          typed;
    int          lspd;
    int          rspd;
  } event_row_t;

  typedef struct packed {
    logic [ModulusWidth-1:0] modulus;
    logic [MaxOvfWidth-1:0]  max_ovf;
    logic [ScaleWidth-1:0]   scale;
    int                      n_items;
    int                      ovf_pct;
    int                      cap_pct;
    int                      ovf_run;
    bit                      rand_cfg;
    bit                      quiet;
  } phase_t;

  // reset settings: modulus 65535, overflow limit 10, scale 1000000
  event_row_t event_rows [21] = '{
    '{0, 0, 16'h0000, 0, 16'h0000, 1, -1, -1},
    '{0, 1, 16'h0000, 1, 16'hFFFF, 1, -1, 15},
    '{0, 1, 16'd1000, 1, 16'h0000, 1, 1000, -1},
    '{1, 0, 16'h0000, 0, 16'h0000, 0, 0, 0},
    '{1, 1, 16'd500,  1, 16'd100,  0, 0, 0},
    '{1, 0, 16'h1234, 0, 16'h4321, 0, 0, 0},
    '{1, 0, 16'h0000, 0, 16'h0000, 0, 0, 0},
    '{1, 0, 16'h0000, 0, 16'h0000, 0, 0, 0},
    '{1, 0, 16'h0000, 0, 16'h0000, 0, 0, 0},
    '{1, 0, 16'h0000, 0, 16'h0000, 0, 0, 0},
    '{1, 0, 16'h0000, 0, 16'h0000, 0, 0, 0},
    '{1, 0, 16'h0000, 0, 16'h0000, 0, 0, 0},
    '{1, 0, 16'h0000, 0, 16'h0000, 0, 0, 0},
    '{1, 0, 16'h0000, 0, 16'h0000, 0, 0, 0},
    '{1, 0, 16'h0000, 0, 16'h0000, 0, 0, 0},
    '{1, 0, 16'hFFFF, 0, 16'hFFFF, 1, -1, -1},
    '{0, 1, 16'hFFFF, 1, 16'hFFFF, 0, 0, 0},
    '{1, 1, 16'hFFFF, 1, 16'h0001, 0, 0, 0},
    '{0, 1, 16'hFFFF, 0, 16'h0000, 0, 0, 0},
    '{1, 1, 16'h5555, 1, 16'hAAAA, 0, 0, 0},
    '{0, 1, 16'hAAAA, 1, 16'h5555, 0, 0, 0}
  };

  phase_t phases [5];

  // predictor state
  logic [ModulusWidth-1:0] modulus_q;
  logic [MaxOvfWidth-1:0]  max_ovf_q;
  logic [ScaleWidth-1:0]   scale_q;
  logic [CaptureWidth-1:0] prev_cap [2];
  int                      interval [2];
  logic [MaxOvfWidth-1:0]  ovf_cnt [2];

  out_t speed_due_q [$];
  int   fail_cnt;
  int   n_events;
  int   n_results;
  int   n_settings;
  int   n_timeouts;
  int   n_sat_holds;
  bit   gaps_on;
  bit   stall_on;

  function automatic out_t advance_wheels(in_t ev);
    logic [CaptureWidth-1:0] cap [2];
    logic                    hit [2];
    logic [31:0]             den;
    logic [31:0]             spd [2];
    out_t                    res;
    int                      w;
    cap[0] = ev.left_capture_value;
    cap[1] = ev.right_capture_value;
    hit[0] = ev.left_capture_event;
    hit[1] = ev.right_capture_event;
    for (w = 0; w < 2; w++) begin
      // overflow goes first, then the capture
      if (ev.overflow_event) begin
        if (ovf_cnt[w] != OvfCountMax) begin
          ovf_cnt[w]++;
        end else begin
          n_sat_holds++;
        end
        if (ovf_cnt[w] > max_ovf_q) begin
          interval[w] = -1;
          n_timeouts++;
        end
      end
      if (hit[w]) begin
        interval[w] = int'(cap[w]) - int'(prev_cap[w]) + int'(ovf_cnt[w]) * int'(modulus_q);
        prev_cap[w] = cap[w];
        ovf_cnt[w] = '0;
      end
      if (interval[w] > 0) begin
        den = unsigned'(interval[w]);
        spd[w] = {1'b0, scale_q} / den;
      end else begin
        spd[w] = '1;
      end
    end
    res.left_speed = spd[0];
    res.right_speed = spd[1];
    return res;
  endfunction

  function automatic logic [CaptureWidth-1:0] pick_capture(logic [CaptureWidth-1:0] prev);
    // a quarter of captures land close to the last one: tiny or negative intervals
    if ($urandom_range(0, 3) == 0) begin
      return prev + CaptureWidth'($urandom_range(0, 48)) - 16'd8;
    end
    return CaptureWidth'($urandom);
  endfunction

  function automatic in_t rand_event(int ovf_pct, int cap_pct);
    in_t ev;
    ev.overflow_event = ($urandom_range(0, 99) < ovf_pct);
    ev.left_capture_event = ($urandom_range(0, 99) < cap_pct);
    ev.right_capture_event = ($urandom_range(0, 99) < cap_pct);
    ev.left_capture_value = pick_capture(prev_cap[0]);
    ev.right_capture_value = pick_capture(prev_cap[1]);
    return ev;
  endfunction

  // valid stays high from one request to the next unless a gap is drawn
  task automatic push_event(in_t ev, bit typed, out_t typed_res);
    int   gap;
    out_t res;
    gap = (gaps_on && $urandom_range(0, 99) < 25) ? $urandom_range(1, 13) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i <= ev;
    do @(posedge clk_i); while (!in_ready_o);
    res = advance_wheels(ev);
    speed_due_q.push_back(typed ? typed_res : res);
    n_events++;
  endtask

  // consecutive writes keep valid high; the caller lowers it
  task automatic write_reg(logic [CfgIndexWidth-1:0] idx, logic [CfgDataWidth-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgModulus: modulus_q = data[ModulusWidth-1:0];
      CfgMaxOvf:  max_ovf_q = data[MaxOvfWidth-1:0];
      CfgScale:   scale_q = data[ScaleWidth-1:0];
      default: ;
    endcase
  endtask

  task automatic settle();
    while (speed_due_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("%0t: run timed out, %0d results still due", $time, speed_due_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // receiver: random stall bursts, checks each result against the oldest due one
  initial begin
    int   stall_left;
    out_t want;
    out_ready_i <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        n_results++;
        if (speed_due_q.size() == 0) begin
          $display("%0t: unexpected result left %0d right %0d", $time,
                   out_o.left_speed, out_o.right_speed);
          fail_cnt++;
        end else begin
          want = speed_due_q.pop_front();
          if (out_o.left_speed !== want.left_speed) begin
            $display("%0t: left_speed expected %0d actual %0d", $time,
                     want.left_speed, out_o.left_speed);
            fail_cnt++;
          end
          if (out_o.right_speed !== want.right_speed) begin
            $display("%0t: right_speed expected %0d actual %0d", $time,
                     want.right_speed, out_o.right_speed);
            fail_cnt++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (stall_on && $urandom_range(0, 99) < 15) begin
        stall_left = $urandom_range(1, 13) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    in_t  ev;
    out_t typed_res;
    int   p;
    int   i;
    fail_cnt = 0;
    n_events = 0;
    n_results = 0;
    n_settings = 1;
    n_timeouts = 0;
    n_sat_holds = 0;
    gaps_on = 1'b1;
    stall_on = 1'b1;
    modulus_q = ModulusReset;
    max_ovf_q = MaxOvfReset;
    scale_q = ScaleReset;
    for (i = 0; i < 2; i++) begin
      prev_cap[i] = '0;
      interval[i] = 0;
      ovf_cnt[i] = '0;
    end
    // extremes first, then a long overflow run to saturate the counts
    phases[0] = '{16'd65535, 8'd254, 31'h7FFF_FFFF, 300, 40, 40, 260, 1'b0, 1'b0};
    phases[1] = '{16'd1, 8'd0, 31'd1, 120, 30, 50, 0, 1'b0, 1'b0};
    phases[2] = '{16'd0, 8'd255, 31'd123457, 120, 70, 20, 0, 1'b0, 1'b0};
    phases[3] = '{16'd0, 8'd0, 31'd0, 150, 35, 45, 0, 1'b1, 1'b0};
    phases[4] = '{16'd1000, 8'd3, 31'd1000000, 150, 25, 60, 0, 1'b0, 1'b1};

    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (event_rows[r]) begin
      ev = '0;
      ev.overflow_event = event_rows[r].ovf;
      ev.left_capture_event = event_rows[r].lc;
      ev.left_capture_value = event_rows[r].lv;
      ev.right_capture_event = event_rows[r].rc;
      ev.right_capture_value = event_rows[r].rv;
      typed_res.left_speed = event_rows[r].lspd;
      typed_res.right_speed = event_rows[r].rspd;
      push_event(ev, event_rows[r].typed, typed_res);
    end
    in_valid_i <= 1'b0;
    settle();

    for (p = 0; p < 5; p++) begin
      if (phases[p].rand_cfg) begin
        phases[p].modulus = ModulusWidth'($urandom_range(1, 65535));
        phases[p].max_ovf = MaxOvfWidth'($urandom_range(0, 12));
        phases[p].scale = ScaleWidth'($urandom_range(1, 32'h7FFF_FFFF));
      end
      // junk in the unused upper bits of the narrow registers
      write_reg(CfgModulus, {15'($urandom), phases[p].modulus});
      write_reg(CfgMaxOvf, {23'($urandom), phases[p].max_ovf});
      write_reg(CfgScale, phases[p].scale);
      cfg_valid_i <= 1'b0;
      n_settings++;
      stall_on = !phases[p].quiet;
      for (i = 0; i < phases[p].n_items; i++) begin
        gaps_on = !phases[p].quiet && ((i / 40) % 3 != 2);
        if (i < phases[p].ovf_run) begin
          // capture flags off, values left as noise
          ev = rand_event(100, 0);
        end else begin
          ev = rand_event(phases[p].ovf_pct, phases[p].cap_pct);
        end
        push_event(ev, 1'b0, '0);
      end
      in_valid_i <= 1'b0;
      settle();
    end

    $display("covered %0d events and %0d results over %0d register settings", n_events,
             n_results, n_settings);
    $display("time-out updates %0d, overflows on a saturated count %0d", n_timeouts,
             n_sat_holds);
    if (fail_cnt == 0 && speed_due_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/dcps_pkg.sv
rtl/dcps_wheel.sv
rtl/dcps_div.sv
rtl/dual_capture_period_speed.sv
dv/dual_capture_period_speed_tb.sv
